// File: rtl/mmh_pkg.sv
package mmh_pkg;

   // Mixing constants
   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned COUNT_W  = 4;
   localparam int unsigned LENGTH_W = 31;

   // How the back end treats one word
   typedef enum logic [1:0] {
      OP_FULL  = 2'd0,
      OP_SHORT = 2'd1,
      OP_EMPTY = 2'd2
   } op_type;

   // One classified word waiting in the queue
   typedef struct packed {
      logic [WORD_W-1:0]   word;
      op_type              op;
      logic                first;
      logic                last;
      logic [LENGTH_W-1:0] length;
   } item_type;

   // Status of the shared multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// File: rtl/mmh_mul.sv
// 64 x 64 -> low 64 multiply by the mixing constant, on one 32 x 32 multiplier.
// Three steps: lo*lo, then lo*hi and hi*lo added into the upper half.
module mmh_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         operand,
   output mmh_pkg::mul_stat_type stat,
   output logic [63:0]         product
);

   localparam logic [31:0] MulLo = mmh_pkg::MIX_MUL[31:0];
   localparam logic [31:0] MulHi = mmh_pkg::MIX_MUL[63:32];

   logic [63:0] op_ff,  op_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] part;

   // operand selection for the shared multiplier
   assign mul_a = (cnt_ff == 2'd2) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b = (cnt_ff == 2'd1) ? MulHi : MulLo;
   assign part  = mul_a * mul_b;

   always_comb begin
      op_in   = op_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         op_in   = operand;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 2'd0) begin
            acc_in = part;
         end else begin
            acc_in = {acc_ff[63:32] + part[31:0], acc_ff[31:0]};
         end
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

// File: rtl/mmh_front.sv
// Accepts key words, classifies them and masks short tails, then queues them
// in a two-entry queue for the back end.
module mmh_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [63:0]           req_key_word,
   input  logic [3:0]            req_valid_bytes,
   input  logic                  req_first_word,
   input  logic                  req_last_word,
   input  logic [30:0]           req_key_length,
   input  logic                  pop,
   output logic                  q_valid,
   output mmh_pkg::item_type     q_item
);

   localparam logic [1:0] QDepth = 2'd2;

   mmh_pkg::item_type entry_ff [2];
   mmh_pkg::item_type new_item;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff,    cnt_in;
   logic              push;
   logic [63:0]       masked;

   // keep only the valid bytes of a short word
   always_comb begin
      masked = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < req_valid_bytes) begin
            masked[8*i +: 8] = req_key_word[8*i +: 8];
         end
      end
   end

   // classification
   always_comb begin
      new_item.first  = req_first_word;
      new_item.last   = req_last_word;
      new_item.length = req_key_length;
      priority if (!req_last_word || req_valid_bytes >= 4'd8) begin
         new_item.op   = mmh_pkg::OP_FULL;
         new_item.word = req_key_word;
      end else if (req_valid_bytes != 4'd0) begin
         new_item.op   = mmh_pkg::OP_SHORT;
         new_item.word = masked;
      end else begin
         new_item.op   = mmh_pkg::OP_EMPTY;
         new_item.word = '0;
      end
   end

   assign req_ready = (cnt_ff != QDepth);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0)
      else $error("queue popped while empty");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count overflow");

endmodule

// File: rtl/mmh_back.sv
// Sequencer: seeds, mixes and finalizes the running hash through the shared
// multiplier, and holds the digest in the output register.
module mmh_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       hash_seed,
   input  logic              q_valid,
   input  mmh_pkg::item_type q_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [63:0]       rsp_digest
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_SEED  = 3'd1,
      S_MIX   = 3'd2,
      S_K1    = 3'd3,
      S_K2    = 3'd4,
      S_H     = 3'd5,
      S_FWAIT = 3'd6,
      S_OUT   = 3'd7
   } state_type;

   state_type             state_ff, state_in;
   mmh_pkg::item_type     item_ff,  item_in;
   logic [63:0]           hash_ff,  hash_in;
   logic [63:0]           fin_ff,   fin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [63:0]           rsp_digest_ff, rsp_digest_in;
   logic                  mul_start;
   logic [63:0]           mul_opnd;
   logic [63:0]           prod;
   logic [63:0]           prod_xs;
   logic [63:0]           hash_xs;
   mmh_pkg::mul_stat_type mul_stat;

   mmh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_opnd),
      .stat    (mul_stat),
      .product (prod)
   );

   assign prod_xs = prod ^ (prod >> mmh_pkg::MIX_SHIFT);
   assign hash_xs = hash_ff ^ (hash_ff >> mmh_pkg::MIX_SHIFT);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      hash_in       = hash_ff;
      fin_in        = fin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_digest_in = rsp_digest_ff;
      pop           = 1'b0;
      mul_start     = 1'b0;
      mul_opnd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               item_in = q_item;
               if (q_item.first) begin
                  mul_start = 1'b1;
                  mul_opnd  = {33'd0, q_item.length};
                  state_in  = S_SEED;
               end else begin
                  state_in = S_MIX;
               end
            end
         end
         S_SEED: begin
            if (mul_stat.done) begin
               hash_in  = hash_seed ^ prod;
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            case (item_ff.op)
               mmh_pkg::OP_FULL: begin
                  mul_start = 1'b1;
                  mul_opnd  = item_ff.word;
                  state_in  = S_K1;
               end
               mmh_pkg::OP_SHORT: begin
                  mul_start = 1'b1;
                  mul_opnd  = hash_ff ^ item_ff.word;
                  state_in  = S_H;
               end
               default: begin
                  // empty key: straight to finalization
                  mul_start = 1'b1;
                  mul_opnd  = hash_xs;
                  state_in  = S_FWAIT;
               end
            endcase
         end
         S_K1: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_opnd  = prod_xs;
               state_in  = S_K2;
            end
         end
         S_K2: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_opnd  = hash_ff ^ prod;
               state_in  = S_H;
            end
         end
         S_H: begin
            if (mul_stat.done) begin
               hash_in = prod;
               if (item_ff.last) begin
                  mul_start = 1'b1;
                  mul_opnd  = prod_xs;
                  state_in  = S_FWAIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FWAIT: begin
            if (mul_stat.done) begin
               fin_in   = prod_xs;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_digest_in = fin_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      fin_ff        <= fin_in;
      rsp_digest_ff <= rsp_digest_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;

   a_start_idle_mul: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!mul_stat.busy && !mul_stat.done))
      else $error("multiplier active while sequencer idle");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output state");

endmodule

// File: rtl/murmur2_64a_hash.sv
// MurmurHash64A streaming hash.
// Request channel (req_*): one 64-bit little-endian key word per transaction,
// with its valid byte count, first/last marks and, on the first word, the
// key length. Non-last words are always hashed as full words.
// Response channel (rsp_*): one 64-bit digest per key, after its last word.
// CSR channel (csr_*): writes the 64-bit seed; csr_ready is always high.
// Write it only while no key is in flight.
// Timing: every 64-bit product runs on one 32x32 multiplier in three steps,
// and that multiplier sets the rate. A full word takes the key product, the
// mixed-key product and the hash product, a short tail only the hash product,
// a first word the seed product first, and a last word a finalization product.
// A two-entry request queue accepts words while the back end is busy.
// Reset clears the seed and running hash to zero and empties queue and output.
// If the receiver stalls, the digest waits in the output register; later
// words keep being hashed until a further digest is ready to go out.
module murmur2_64a_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_key_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [30:0] req_key_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_hash_seed
);

   logic [63:0]       hash_seed_ff, hash_seed_in;
   logic              q_valid;
   logic              pop;
   mmh_pkg::item_type q_item;

   // seed register
   assign csr_ready    = 1'b1;
   assign hash_seed_in = (csr_valid && csr_ready) ? csr_hash_seed : hash_seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff <= '0;
      end else begin
         hash_seed_ff <= hash_seed_in;
      end
   end

   mmh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_word    (req_key_word),
      .req_valid_bytes (req_valid_bytes),
      .req_first_word  (req_first_word),
      .req_last_word   (req_last_word),
      .req_key_length  (req_key_length),
      .pop             (pop),
      .q_valid         (q_valid),
      .q_item          (q_item)
   );

   mmh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hash_seed  (hash_seed_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_digest (rsp_digest)
   );

endmodule

// File: verif/murmur2_64a_hash_check.sv
module murmur2_64a_hash_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_key_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic [30:0] req_key_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_digest,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [63:0] csr_hash_seed,
   output int          fail_count,
   output int          digests_pending,
   output int          digests_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the block's seed register and running hash
   logic [63:0] seed_shadow = '0;
   logic [63:0] hash_shadow = '0;
   logic [63:0] digest_queue[$];
   int          mismatches = 0;
   int          compared = 0;

   // Full 8-byte word folded into the hash
   function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [63:0] k);
      logic [63:0] kk;
      kk = k * mmh_pkg::MIX_MUL;
      kk = kk ^ (kk >> mmh_pkg::MIX_SHIFT);
      kk = kk * mmh_pkg::MIX_MUL;
      return (h ^ kk) * mmh_pkg::MIX_MUL;
   endfunction

   // Avalanche step applied after the last word
   function automatic logic [63:0] scramble_out(input logic [63:0] h);
      logic [63:0] x;
      x = h ^ (h >> mmh_pkg::MIX_SHIFT);
      x = x * mmh_pkg::MIX_MUL;
      return x ^ (x >> mmh_pkg::MIX_SHIFT);
   endfunction

   // Track every transaction at the clock edge
   always @(posedge clock) begin : track
      logic [63:0] h;
      logic [63:0] want;
      if (reset) begin
         seed_shadow = '0;
         hash_shadow = '0;
         digest_queue.delete();
      end else begin
         // seed write
         if (csr_valid && csr_ready)
            seed_shadow = csr_hash_seed;

         // digest out: compare against oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               mismatches++;
               $display("%0t ns: digest with none expected: expected none, actual %h",
                        $time, rsp_digest);
            end else begin
               want = digest_queue.pop_front();
               compared++;
               if (rsp_digest !== want) begin
                  mismatches++;
                  $display("%0t ns: digest mismatch: expected %h, actual %h",
                           $time, want, rsp_digest);
               end
            end
         end

         // key word in
         if (req_valid && req_ready) begin
            h = req_first_word
                ? (seed_shadow ^ (64'(req_key_length) * mmh_pkg::MIX_MUL))
                : hash_shadow;
            // non-last words count as full; 9..15 saturate to a full word
            if (!req_last_word || req_valid_bytes >= 4'd8)
               h = absorb_word(h, req_key_word);
            else if (req_valid_bytes != 4'd0)
               h = (h ^ (req_key_word & ((64'd1 << (8 * req_valid_bytes)) - 64'd1)))
                   * mmh_pkg::MIX_MUL;
            hash_shadow = h;
            if (req_last_word)
               digest_queue.push_back(scramble_out(h));
         end
      end
      fail_count <= mismatches;
      digests_pending <= digest_queue.size();
      digests_seen <= compared;
   end

endmodule

// File: verif/murmur2_64a_hash_test.sv
module murmur2_64a_hash_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 80;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [30:0] MAX_LENGTH = 31'h7fff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_key_word = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_first_word = 1'b0;
   logic        req_last_word = 1'b0;
   logic [30:0] req_key_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_digest;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_hash_seed = '0;

   int fail_count;
   int digests_pending;
   int digests_seen;
   int send_idle = 0;
   int recv_idle = 0;
   int words_sent = 0;
   int seed_writes = 0;

   murmur2_64a_hash uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_word    (req_key_word),
      .req_valid_bytes (req_valid_bytes),
      .req_first_word  (req_first_word),
      .req_last_word   (req_last_word),
      .req_key_length  (req_key_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest      (rsp_digest),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_seed   (csr_hash_seed)
   );

   murmur2_64a_hash_check hash_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_word    (req_key_word),
      .req_valid_bytes (req_valid_bytes),
      .req_first_word  (req_first_word),
      .req_last_word   (req_last_word),
      .req_key_length  (req_key_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest      (rsp_digest),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_seed   (csr_hash_seed),
      .fail_count      (fail_count),
      .digests_pending (digests_pending),
      .digests_seen    (digests_seen)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // Hard stop
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // One key word transaction; returns at the accepting edge
   task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                            input logic first, input logic last,
                            input logic [30:0] length);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid       <= 1'b1;
      req_key_word    <= word;
      req_valid_bytes <= count;
      req_first_word  <= first;
      req_last_word   <= last;
      req_key_length  <= length;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Drain: all digests back, then let trailing non-last words finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (digests_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] seed);
      csr_valid     <= 1'b1;
      csr_hash_seed <= seed;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      seed_writes++;
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(19))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Well-formed key, with occasional broken marks or a wrong length
   task automatic send_key(input int nbytes);
      int          nwords;
      int          tail;
      logic [30:0] length;
      logic [3:0]  count;
      logic        first_mark;
      nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
      tail   = nbytes - 8 * (nwords - 1);
      length = ($urandom_range(99) < 85) ? 31'(nbytes)
             : ($urandom_range(9) == 0 ? MAX_LENGTH : 31'($urandom));
      first_mark = ($urandom_range(99) >= 5);
      for (int i = 0; i < nwords; i++) begin
         if (i == nwords - 1) begin
            count = 4'(tail);
            if (tail == 8 && $urandom_range(9) == 0)
               count = 4'($urandom_range(15, 9));
         end else begin
            count = ($urandom_range(99) < 80) ? 4'd8 : 4'($urandom_range(15));
         end
         send_word(random_word(), count, first_mark && i == 0, i == nwords - 1, length);
      end
   endtask

   task automatic run_phase(input int sidle, input int ridle, input logic [63:0] seed,
                            input int target);
      int start;
      int pick;
      start = words_sent;
      send_idle = sidle;
      recv_idle = ridle;
      write_seed(seed);
      while (words_sent - start < target) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_word(random_word(), 4'($urandom_range(15)), 1'($urandom),
                      1'($urandom), 31'($urandom));
         else if (pick < 70)
            send_key($urandom_range(24));
         else if (pick < 92)
            send_key($urandom_range(64, 25));
         else
            send_key($urandom_range(200, 65));
      end
      wait_idle();
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, seed at its reset value of zero
      send_word(64'h0123_4567_89ab_cdef, 4'd2, 1'b0, 1'b1, 31'd0); // unmarked right after reset
      send_word(64'h0, 4'd0, 1'b1, 1'b1, 31'd0);                     // empty key
      send_word(ALL_ONES, 4'd1, 1'b1, 1'b1, 31'd1);
      send_word(ALL_ONES, 4'd7, 1'b1, 1'b1, 31'd7);
      send_word(ALL_ONES, 4'd8, 1'b1, 1'b1, MAX_LENGTH);
      send_word(64'haaaa_aaaa_aaaa_aaaa, 4'd15, 1'b1, 1'b1, 31'd8);  // count saturates
      // three words; counts on non-last words are ignored
      send_word(64'h0, 4'd3, 1'b1, 1'b0, 31'd20);
      send_word(64'h5555_5555_5555_5555, 4'd0, 1'b0, 1'b0, 31'd20);
      send_word(64'hdead_beef_cafe_f00d, 4'd4, 1'b0, 1'b1, 31'd20);
      // continues from the previous key's pre-final hash
      send_word(64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b1, 31'd0);
      send_word(64'h1357_9bdf_2468_ace0, 4'd9, 1'b0, 1'b0, 31'd0);
      send_word(64'hfedc_ba98_7654_3210, 4'd6, 1'b0, 1'b1, 31'd0);
      // length disagrees with data
      send_word(64'h0f0f_0f0f_0f0f_0f0f, 4'd5, 1'b1, 1'b1, 31'd1000);
      // key restarted mid-stream by a new first mark
      send_word(64'h1111_2222_3333_4444, 4'd8, 1'b1, 1'b0, 31'd16);
      send_word(64'h5555_6666_7777_8888, 4'd8, 1'b1, 1'b1, 31'd8);
      wait_idle();

      // Directed, all-ones seed
      write_seed(ALL_ONES);
      send_word(64'h0, 4'd0, 1'b1, 1'b1, 31'd0);
      send_word(ALL_ONES, 4'd8, 1'b1, 1'b1, 31'd8);
      send_word(64'h7f7f_7f7f_7f7f_7f7f, 4'd3, 1'b1, 1'b1, MAX_LENGTH);
      wait_idle();

      // Random keys under three pacing profiles
      run_phase(24, 86, {$urandom, $urandom}, 234);
      run_phase(86, 24, 64'h8000_0000_0000_0001, 234);
      run_phase(0, 0, 64'h0, 234);

      $display("Covered %0d key words and %0d digests over %0d seed writes,", words_sent,
               digests_seen, seed_writes);
      $display("three pacing profiles, empty/short/full/saturated tails and broken keys.");
      if (fail_count == 0 && digests_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
